// File: design/assert_macros.svh
// Assertion macros used by the range_index_map top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: design/rim_pkg.sv
// Types and constants for the range index map.
`timescale 1ns / 1ps
package rim_pkg;

  localparam int unsigned CodeW = 21;
  localparam logic [CodeW-1:0] CodeMax = {CodeW{1'b1}};

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_I2C    = 2'd2;
  localparam logic [1:0] KIND_C2I    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ORDER     = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CodeW-1:0] first_code;
    logic [CodeW-1:0] last_code;
    logic [CodeW-1:0] key;
  } rim_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CodeW-1:0] value;
    logic [CodeW-1:0] total_items;
  } rim_out_t;

  // One range entry as it moves along the cell chain.
  typedef struct packed {
    logic [CodeW-1:0] first_code;
    logic [CodeW-1:0] last_code;
    logic [CodeW-1:0] base;
  } rim_entry_t;

  // Probe travelling with the rotation: a lookup question and its answer.
  typedef struct packed {
    logic [1:0]       kind;
    logic [CodeW-1:0] key;
    logic             found;
    logic [CodeW-1:0] value;
  } rim_probe_t;

  function automatic logic [CodeW-1:0] sat_add(input logic [CodeW-1:0] a,
                                               input logic [CodeW-1:0] b);
    logic [CodeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CodeW] ? CodeMax : s[CodeW-1:0];
  endfunction

endpackage

// File: design/rim_cell.sv
// One storage cell of the range chain: holds an entry and passes it along.
`timescale 1ns / 1ps
module rim_cell import rim_pkg::*; (
  input  logic       clk,
  input  logic       shift,
  input  rim_entry_t entry_in,
  output rim_entry_t entry_out
);

  rim_entry_t entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= entry_in;
    end
  end

  assign entry_out = entry;

endmodule

// File: design/rim_match.sv
// Lookup check of the entry at the head of the chain against the probe.
`timescale 1ns / 1ps
module rim_match import rim_pkg::*; (
  input  rim_entry_t entry,
  input  rim_probe_t probe,
  output logic       hit,
  output logic [CodeW-1:0] value
);

  logic [CodeW-1:0] span;
  logic [CodeW:0]   top_wide;

  always_comb begin
    span     = entry.last_code - entry.first_code;
    top_wide = {1'b0, entry.base} + {1'b0, span};
    hit      = 1'b0;
    value    = '0;
    if (probe.kind == KIND_I2C) begin
      // Top of the range may run past 21 bits once the total saturates.
      // Below the saturated top index the matching range is unique.
      hit   = (probe.key >= entry.base) && ({1'b0, probe.key} <= top_wide);
      value = entry.first_code + (probe.key - entry.base);
    end else begin
      hit   = (probe.key >= entry.first_code) && (probe.key <= entry.last_code);
      value = sat_add(entry.base, probe.key - entry.first_code);
    end
  end

endmodule

// File: design/range_index_map.sv
// Range index map top level: chain of range cells with a rotating lookup.
//
// The table is a ring of RANGE_ENTRIES cells. Appends shift a new entry in at
// the tail so entries sit in load order. A lookup rotates the ring once, one
// cell per cycle past the match unit at the head, and the first hit wins;
// the rotation is a full turn whatever the table fill. Clear and append
// answer in the cycle after they are accepted.
// Index lookups at the saturated top index can match several ranges; there
// the pick follows the binary search path, whose probes only move forward,
// so it is tracked during the same rotation.
// An append with a full table rejects without touching the ring. busy is
// high while a lookup rotates; each result appears for one cycle with done
// high and cannot be held off by the receiver.
`timescale 1ns / 1ps
module range_index_map import rim_pkg::*; #(
  parameter int RANGE_ENTRIES = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rim_in_t  item,
  output logic     busy,
  output logic     done,
  output rim_out_t result
);
`include "assert_macros.svh"

  localparam int CntW = $clog2(RANGE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROT  = 2'd1;

  logic [1:0]      state;
  logic [CntW-1:0] entry_count;
  logic [CntW-1:0] rot_cnt;
  logic [CodeW-1:0] running_total;
  rim_probe_t      probe;

  rim_entry_t chain [RANGE_ENTRIES];
  rim_entry_t feed  [RANGE_ENTRIES];
  rim_entry_t new_entry;
  logic       shift;
  logic       accept;
  logic       do_append;
  logic       hit;
  logic [CodeW-1:0] hit_value;
  logic [CodeW-1:0] len_m1;
  logic [CodeW:0]   grown;

  // Binary search tracking for the saturated top index: mid and exclusive hi.
  logic [CntW-1:0] bs_mid;
  logic [CntW-1:0] bs_hi;
  logic            bs_live;
  logic [CntW-1:0] bs_at;
  logic [CntW:0]   bs_sum;
  logic [CntW-1:0] bs_next;
  logic            bs_mode;
  logic            bs_here;
  logic            bs_step;
  logic            head_take;

  assign accept = start && !busy;
  assign busy   = (state == S_ROT);

  // Append is legal when the table has room and bounds are ordered.
  assign do_append = accept && (item.kind == KIND_APPEND) &&
                     (entry_count < CntW'(RANGE_ENTRIES)) &&
                     (item.last_code >= item.first_code);

  assign new_entry.first_code = item.first_code;
  assign new_entry.last_code  = item.last_code;
  assign new_entry.base       = running_total;

  // Append shifts the ring toward the head with the new entry at the tail and
  // drops the old head. A lookup moves the head to the tail, so after
  // a full turn the order is back where it began.
  assign shift = do_append || busy;

  genvar g;
  generate
    for (g = 0; g < RANGE_ENTRIES; g++) begin : g_cell
      if (g == RANGE_ENTRIES - 1) begin : g_tail
        assign feed[g] = busy ? chain[0] : new_entry;
      end else begin : g_mid
        assign feed[g] = chain[g+1];
      end
      rim_cell u_cell (
        .clk      (clk),
        .shift    (shift),
        .entry_in (feed[g]),
        .entry_out(chain[g])
      );
    end
  endgenerate

  // Entries live in the top entry_count cells; the head cell is valid while
  // the rotation count lies in the last entry_count steps.
  logic head_valid;
  assign head_valid = (rot_cnt >= CntW'(RANGE_ENTRIES) - entry_count);

  rim_match u_match (
    .entry(chain[0]),
    .probe(probe),
    .hit  (hit),
    .value(hit_value)
  );

  // At the saturated top index every probe lands at or above its base, so a
  // miss always moves the search right: next mid is (mid + hi) / 2.
  assign bs_mode   = (probe.kind == KIND_I2C) && (probe.key == CodeMax);
  assign bs_at     = CntW'(RANGE_ENTRIES) - entry_count + bs_mid;
  assign bs_here   = bs_live && (rot_cnt == bs_at);
  assign bs_sum    = {1'b0, bs_mid} + {1'b0, bs_hi};
  assign bs_next   = bs_sum[CntW:1];
  assign bs_step   = bs_mode && bs_here && !hit;
  assign head_take = bs_mode ? (bs_here && hit) : (head_valid && hit);

  assign len_m1 = item.last_code - item.first_code;
  assign grown  = {1'b0, running_total} + {1'b0, len_m1} + (CodeW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      running_total <= '0;
      done          <= 1'b0;
      rot_cnt       <= '0;
      probe.found   <= 1'b0;
      bs_live       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            result.value <= '0;
            case (item.kind)
              KIND_CLEAR: begin
                entry_count          <= '0;
                running_total        <= '0;
                result.status        <= ST_OK;
                result.total_items   <= '0;
                done                 <= 1'b1;
              end
              KIND_APPEND: begin
                result.total_items <= running_total;
                done               <= 1'b1;
                if (entry_count >= CntW'(RANGE_ENTRIES)) begin
                  result.status <= ST_FULL;
                end else if (item.last_code < item.first_code) begin
                  result.status <= ST_ORDER;
                end else begin
                  result.status      <= ST_OK;
                  entry_count        <= entry_count + CntW'(1);
                  running_total      <= grown[CodeW] ? CodeMax : grown[CodeW-1:0];
                  result.total_items <= grown[CodeW] ? CodeMax : grown[CodeW-1:0];
                end
              end
              default: begin
                probe.kind  <= item.kind;
                probe.key   <= item.key;
                probe.found <= 1'b0;
                probe.value <= '0;
                rot_cnt     <= '0;
                bs_hi       <= entry_count;
                bs_mid      <= (entry_count - CntW'(1)) >> 1;
                bs_live     <= (entry_count != '0);
                state       <= S_ROT;
              end
            endcase
          end
        end
        S_ROT: begin
          if (!probe.found && head_take) begin
            probe.found <= 1'b1;
            probe.value <= hit_value;
          end
          if (bs_step) begin
            bs_mid  <= bs_next;
            bs_live <= (bs_mid + CntW'(1) < bs_hi);
          end
          if (rot_cnt == CntW'(RANGE_ENTRIES - 1)) begin
            state              <= S_IDLE;
            done               <= 1'b1;
            result.total_items <= running_total;
            if (!probe.found && head_take) begin
              result.status <= ST_OK;
              result.value  <= hit_value;
            end else if (probe.found) begin
              result.status <= ST_OK;
              result.value  <= probe.value;
            end else begin
              result.status <= ST_NOT_FOUND;
              result.value  <= '0;
            end
          end
          rot_cnt <= rot_cnt + CntW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, entry_count <= CntW'(RANGE_ENTRIES),
                "entry count beyond table depth")
  `ASSERT_NEXT(a_quick_done, clk, rst, accept && (item.kind == KIND_CLEAR ||
               item.kind == KIND_APPEND), done && !busy, "clear/append missed result")
  `ASSERT_IMPLY(a_no_done_busy, clk, rst, busy, !done, "result during rotation")
  `ASSERT_NEXT(a_lookup_busy, clk, rst, accept && (item.kind == KIND_I2C ||
               item.kind == KIND_C2I), busy, "lookup did not start rotation")

endmodule

// File: test/tb_range_index_map.sv
// Testbench for range_index_map: queued command stimulus, result checker.
`timescale 1ns / 1ps
module tb_range_index_map;
  import rim_pkg::*;

  localparam int Entries = 256;
  localparam int RandItems = 1624;

  logic     clk;
  logic     rst;
  logic     start;
  rim_in_t  item;
  logic     busy;
  logic     done;
  rim_out_t result;

  range_index_map #(.RANGE_ENTRIES(Entries)) uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the range table, updated as each transfer is accepted.
  logic [CodeW-1:0] tbl_first [Entries];
  logic [CodeW-1:0] tbl_last [Entries];
  logic [CodeW-1:0] tbl_base [Entries];
  int unsigned      tbl_count;
  logic [CodeW-1:0] tbl_total;

  rim_in_t  pending_cmds[$];
  rim_out_t expected_results[$];
  int       mismatches;
  int       cycle_no;
  bit       stim_done;

  // Work out the one result of a command and apply it to the shadow table.
  function automatic rim_out_t map_command(input rim_in_t c);
    rim_out_t r;
    int lo, hi, mid;
    logic [CodeW:0] top, s;
    r.status = ST_OK;
    r.value = '0;
    case (c.kind)
      KIND_CLEAR: begin
        tbl_count = 0;
        tbl_total = '0;
      end
      KIND_APPEND: begin
        if (tbl_count >= Entries) r.status = ST_FULL;
        else if (c.last_code < c.first_code) r.status = ST_ORDER;
        else begin
          tbl_first[tbl_count] = c.first_code;
          tbl_last[tbl_count] = c.last_code;
          tbl_base[tbl_count] = tbl_total;
          tbl_count++;
          s = {1'b0, tbl_total} + (c.last_code - c.first_code) + (CodeW+1)'(1);
          tbl_total = s[CodeW] ? CodeMax : s[CodeW-1:0];
        end
      end
      KIND_I2C: begin
        // binary search over bases; top may pass 21 bits
        r.status = ST_NOT_FOUND;
        lo = 0;
        hi = int'(tbl_count) - 1;
        while (hi >= lo) begin
          mid = (lo + hi) / 2;
          top = {1'b0, tbl_base[mid]} + (tbl_last[mid] - tbl_first[mid]);
          if ({1'b0, c.key} > top) lo = mid + 1;
          else if (c.key < tbl_base[mid]) hi = mid - 1;
          else begin
            r.status = ST_OK;
            r.value = tbl_first[mid] + (c.key - tbl_base[mid]);
            break;
          end
        end
      end
      default: begin
        // in-order walk, first hit wins
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < int'(tbl_count); i++) begin
          if (c.key >= tbl_first[i] && c.key <= tbl_last[i]) begin
            s = {1'b0, tbl_base[i]} + (c.key - tbl_first[i]);
            r.status = ST_OK;
            r.value = s[CodeW] ? CodeMax : s[CodeW-1:0];
            break;
          end
        end
      end
    endcase
    r.total_items = tbl_total;
    return r;
  endfunction

  function automatic rim_in_t make_cmd(input logic [1:0] k, input int unsigned f,
                                       input int unsigned l, input int unsigned y);
    rim_in_t c;
    c.kind = k;
    c.first_code = CodeW'(f);
    c.last_code = CodeW'(l);
    c.key = CodeW'(y);
    return c;
  endfunction

  // Random key: mostly near the given low code or total, sometimes anywhere.
  function automatic logic [CodeW-1:0] pick_key(input logic [1:0] k,
                                                input logic [CodeW-1:0] lo_code,
                                                input logic [CodeW-1:0] total);
    case ($urandom_range(0, 3))
      0: return CodeW'($urandom);
      1: return lo_code + CodeW'($urandom_range(0, 40));
      default: return (k == KIND_I2C) ? total - CodeW'($urandom_range(0, 60))
                                      : lo_code + CodeW'($urandom_range(0, 300));
    endcase
  endfunction

  // Driver: offer the next queued command, idling now and then.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // previous transfer (if any) was taken at this edge
      if (start) void'(pending_cmds.pop_front());
      if (pending_cmds.size() > 0 &&
          (cycle_no inside {[3000:9000]} || $urandom_range(0, 99) >= 16)) begin
        start <= 1'b1;
        item <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the shadow table follows transfer order.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst && start && !busy) expected_results.push_back(map_command(item));
  end

  // Monitor: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        if (result.status !== expected_results[0].status ||
            result.value !== expected_results[0].value ||
            result.total_items !== expected_results[0].total_items) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", expected_results[0], result);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    int unsigned f, l, n;
    logic [1:0] k;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    mismatches = 0;
    cycle_no = 0;
    stim_done = 1'b0;
    tbl_count = 0;
    tbl_total = '0;

    // Directed: empty-table lookups, extremes, bad order, saturation, full table.
    pending_cmds.push_back(make_cmd(KIND_I2C, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_C2I, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_APPEND, 5, 4, 0));
    pending_cmds.push_back(make_cmd(KIND_APPEND, 'h41, 'h5A, 0));
    pending_cmds.push_back(make_cmd(KIND_APPEND, 'h61, 'h7A, 0));
    pending_cmds.push_back(make_cmd(KIND_APPEND, 'h50, 'h70, 0)); // overlaps: first wins
    pending_cmds.push_back(make_cmd(KIND_C2I, 0, 0, 'h55));
    pending_cmds.push_back(make_cmd(KIND_C2I, 0, 0, 'h65));
    pending_cmds.push_back(make_cmd(KIND_I2C, 0, 0, 30));
    pending_cmds.push_back(make_cmd(KIND_I2C, 0, 0, 200));
    pending_cmds.push_back(make_cmd(KIND_APPEND, 0, 'h1FFFFF, 0)); // saturates total
    pending_cmds.push_back(make_cmd(KIND_APPEND, 'h1FFFFF, 'h1FFFFF, 0));
    pending_cmds.push_back(make_cmd(KIND_C2I, 0, 0, 'h1FFFFF));
    pending_cmds.push_back(make_cmd(KIND_C2I, 0, 0, 'h10FFFF));
    pending_cmds.push_back(make_cmd(KIND_I2C, 0, 0, 'h1FFFFF));
    pending_cmds.push_back(make_cmd(KIND_CLEAR, 'h1FFFFF, 'h1FFFFF, 'h1FFFFF));
    for (int i = 0; i < Entries; i++)
      pending_cmds.push_back(make_cmd(KIND_APPEND, i * 3, i * 3 + 1, 0));
    pending_cmds.push_back(make_cmd(KIND_APPEND, 1, 0, 0)); // full before order
    pending_cmds.push_back(make_cmd(KIND_I2C, 0, 0, 511));
    pending_cmds.push_back(make_cmd(KIND_C2I, 0, 0, 765));
    pending_cmds.push_back(make_cmd(KIND_CLEAR, 0, 0, 0));

    // Random: well-formed table builds with lookups, plus bad appends.
    n = 0;
    f = 0;
    while (n < RandItems) begin
      k = $urandom_range(0, 99) < 3 ? KIND_CLEAR :
          $urandom_range(0, 99) < 35 ? KIND_APPEND :
          ($urandom_range(0, 1) ? KIND_I2C : KIND_C2I);
      if (k == KIND_APPEND) begin
        if ($urandom_range(0, 15) == 0) begin
          f = $urandom;
          l = $urandom;
        end else begin
          f = $urandom_range(0, 1) ? $urandom_range(0, 'h10FFFF) : f + $urandom_range(0, 50);
          f = f & 'h1FFFFF;
          l = ($urandom_range(0, 19) == 0) ? f - 1 : f + $urandom_range(0, 100);
          if (l > 'h1FFFFF) l = 'h1FFFFF;
        end
        pending_cmds.push_back(make_cmd(k, f, l & 'h1FFFFF, $urandom));
      end else begin
        pending_cmds.push_back(make_cmd(k, $urandom, $urandom,
                                        pick_key(k, CodeW'(f),
                                                 n[CodeW-1:0] * CodeW'(20))));
      end
      n++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (Entries + 20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
